// ===== sv/lru_pkg.sv =====
// Shared constants for the LRU page replacement block.
// No dependencies; imported by the top level and its port checker.
package lru_pkg;

  localparam int CFG_W       = 4;
  localparam int FRAME_IDX_W = 3;
  localparam int COUNT_W     = 32;

  localparam logic [CFG_W-1:0]   FRAMES_RESET = 4'd3;
  localparam logic [COUNT_W-1:0] FAULT_MAX    = '1;

endpackage

// ===== sv/lru_page_replacement_top.sv =====
// LRU page replacement: fully associative frame set with recency ranks.
// Depends on lru_pkg.
//
// Usage:
//   Config channel (cfg_valid/cfg_ready, data frames_in_use) sets the number
//   of active frames; ready is always high. Write only while idle.
//   Input channel (in_valid/in_stall, page_number) takes one page reference
//   per word. Output channel (out_valid/out_stall) returns one result word
//   per reference: fault, frame_index, evicted_valid, evicted_page and the
//   saturating fault_total.
// Timing: the accept edge loads the input register; tag compare, victim pick
//   and rank update load the result register when out_stall allows.
// Throughput: 1 word per cycle while out_stall is low. The frame state
//   updates in the same cycle the result is registered, so the next word
//   sees it without a bubble.
// Reset: frames empty, ranks and fault count zero, frames_in_use = 3, both
//   pipeline stages empty.
// Stall: while out_stall holds a result, the input register holds its word
//   and in_stall rises once that register is full; nothing is dropped.
module lru_page_replacement_top #(
  parameter int MAX_FRAMES = 8,
  parameter int PAGE_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lru_pkg::CFG_W-1:0]     frames_in_use,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [PAGE_BITS-1:0]          page_number,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          fault,
  output logic [lru_pkg::FRAME_IDX_W-1:0] frame_index,
  output logic                          evicted_valid,
  output logic [PAGE_BITS-1:0]          evicted_page,
  output logic [lru_pkg::COUNT_W-1:0]   fault_total
);
  import lru_pkg::*;

  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int AGE_W = IDX_W;
  localparam int LIM_W = CFG_W + 1;

  logic [CFG_W-1:0]     frames_cfg;
  logic                 in_v;
  logic [PAGE_BITS-1:0] in_page;
  logic [PAGE_BITS-1:0] frame_page [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] frame_valid;
  logic [AGE_W-1:0]     frame_age [MAX_FRAMES];
  logic [COUNT_W-1:0]   fault_cnt;

  logic                 advance;
  logic [LIM_W-1:0]     active_lim;
  logic [MAX_FRAMES-1:0] act, hit_vec, empty_vec, vict_vec;
  logic                 hit, empty_any;
  logic [IDX_W-1:0]     hit_idx, empty_idx, vict_idx, chosen;
  logic [AGE_W:0]       limit;
  logic [AGE_W-1:0]     frame_age_next [MAX_FRAMES];
  logic [COUNT_W-1:0]   fault_cnt_next;

  assign cfg_ready = 1'b1;
  assign in_stall  = in_v && out_valid && out_stall;
  assign advance   = in_v && (!out_valid || !out_stall);

  always_comb begin
    if (frames_cfg == '0) begin
      active_lim = LIM_W'(1);
    end else if ({1'b0, frames_cfg} > LIM_W'(MAX_FRAMES)) begin
      active_lim = LIM_W'(MAX_FRAMES);
    end else begin
      active_lim = {1'b0, frames_cfg};
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_FRAMES; i++) begin
      act[i]       = LIM_W'(i) < active_lim;
      hit_vec[i]   = act[i] && frame_valid[i] && (frame_page[i] == in_page);
      empty_vec[i] = act[i] && !frame_valid[i];
    end
  end

  // Victim: strictly older than every active frame below, not younger than any above.
  always_comb begin
    for (int i = 0; i < MAX_FRAMES; i++) begin
      vict_vec[i] = act[i];
      for (int j = 0; j < MAX_FRAMES; j++) begin
        if (j < i && act[j] && !(frame_age[i] > frame_age[j])) begin
          vict_vec[i] = 1'b0;
        end
        if (j > i && act[j] && (frame_age[i] < frame_age[j])) begin
          vict_vec[i] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    hit_idx   = '0;
    empty_idx = '0;
    vict_idx  = '0;
    for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (empty_vec[i]) begin
        empty_idx = IDX_W'(i);
      end
      if (vict_vec[i]) begin
        vict_idx = IDX_W'(i);
      end
    end
  end

  assign hit       = |hit_vec;
  assign empty_any = |empty_vec;

  always_comb begin
    priority if (hit) begin
      chosen = hit_idx;
      limit  = {1'b0, frame_age[hit_idx]};
    end else if (empty_any) begin
      chosen = empty_idx;
      limit  = (AGE_W+1)'(MAX_FRAMES);
    end else begin
      chosen = vict_idx;
      limit  = {1'b0, frame_age[vict_idx]};
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_FRAMES; i++) begin
      if (IDX_W'(i) == chosen) begin
        frame_age_next[i] = '0;
      end else if (frame_valid[i] && ({1'b0, frame_age[i]} < limit) &&
                   ({1'b0, frame_age[i]} < (AGE_W+1)'(MAX_FRAMES - 1))) begin
        frame_age_next[i] = frame_age[i] + AGE_W'(1);
      end else begin
        frame_age_next[i] = frame_age[i];
      end
    end
  end

  assign fault_cnt_next = (fault_cnt == FAULT_MAX) ? fault_cnt : fault_cnt + COUNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_cfg  <= FRAMES_RESET;
      in_v        <= 1'b0;
      out_valid   <= 1'b0;
      frame_valid <= '0;
      fault_cnt   <= '0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
        frame_age[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        frames_cfg <= frames_in_use;
      end
      if (!in_stall) begin
        in_v <= in_valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        frame_valid[chosen] <= 1'b1;
        for (int i = 0; i < MAX_FRAMES; i++) begin
          frame_age[i] <= frame_age_next[i];
        end
        if (!hit) begin
          fault_cnt <= fault_cnt_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_page <= page_number;
    end
    if (advance && !hit) begin
      frame_page[chosen] <= in_page;
    end
    if (advance) begin
      fault         <= !hit;
      frame_index   <= FRAME_IDX_W'(chosen);
      evicted_valid <= !hit && !empty_any;
      evicted_page  <= (!hit && !empty_any) ? frame_page[chosen] : '0;
      fault_total   <= hit ? fault_cnt : fault_cnt_next;
    end
  end

endmodule

// ===== sv/lru_checker.sv =====
// Port-level checks for the LRU page replacement top level, bound to it.
// Depends on lru_pkg and lru_page_replacement_top.
module lru_checker #(
  parameter int PAGE_BITS = 16
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic                            fault,
  input logic [lru_pkg::FRAME_IDX_W-1:0] frame_index,
  input logic                            evicted_valid,
  input logic [PAGE_BITS-1:0]            evicted_page,
  input logic [lru_pkg::COUNT_W-1:0]     fault_total
);
  import lru_pkg::*;

  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word present after reset");

  a_evict_needs_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid && evicted_valid |-> fault)
    else $error("eviction reported on a hit");

  a_no_evict_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !evicted_valid |-> evicted_page == '0)
    else $error("evicted page nonzero without eviction");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(fault_total) && $stable(frame_index)
      && $stable(evicted_page) && $stable(fault))
    else $error("stalled result word changed");

  a_fault_counted: assert property (@(posedge clk) disable iff (rst)
    out_valid && fault |-> fault_total != '0)
    else $error("fault word with zero fault total");

endmodule

bind lru_page_replacement_top lru_checker #(.PAGE_BITS(PAGE_BITS)) u_lru_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .fault        (fault),
  .frame_index  (frame_index),
  .evicted_valid(evicted_valid),
  .evicted_page (evicted_page),
  .fault_total  (fault_total)
);
